// ===== rtl/ucep_pkg.sv =====
// Shared types and codes for the endpoint-zero control transfer sequencer.
// No dependencies; imported by usb_control_endpoint_sequencer.
package ucep_pkg;

  // Largest request length the control data buffer can take, in bytes
  localparam int BUF_BYTES = 4096;
  // A setup packet carries exactly this many bytes
  localparam logic [12:0] SETUP_LEN = 13'd8;
  // Direction bit of the request type byte (device to host)
  localparam int DIR_IN_BIT = 7;

  // Token kinds, carried in tuser
  localparam logic [2:0] CMD_SETUP     = 3'd0;
  localparam logic [2:0] CMD_IN        = 3'd1;
  localparam logic [2:0] CMD_OUT       = 3'd2;
  localparam logic [2:0] CMD_PARAM_OUT = 3'd3;
  localparam logic [2:0] CMD_PARAM_IN  = 3'd4;

  // Packet and handler result codes
  localparam logic [1:0] RS_OK    = 2'd0;
  localparam logic [1:0] RS_STALL = 2'd1;
  localparam logic [1:0] RS_ASYNC = 2'd2;
  localparam logic [1:0] RS_BAD   = 2'd3;

  // Copy directions
  localparam logic [1:0] CD_NONE   = 2'd0;
  localparam logic [1:0] CD_TO_BUF = 2'd1;
  localparam logic [1:0] CD_TO_PKT = 2'd2;

  typedef enum logic [4:0] {
    STG_IDLE  = 5'b00001,
    STG_SETUP = 5'b00010,
    STG_DATA  = 5'b00100,
    STG_ACK   = 5'b01000,
    STG_PARAM = 5'b10000
  } stage_t;

  // Input token word, last field in the lowest bits
  typedef struct packed {
    logic [15:0] handler_length;
    logic [1:0]  handler_status;
    logic [12:0] packet_size;
    logic [63:0] setup_word;
  } token_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [15:0] req_index;
    logic [15:0] req_value;
    logic [15:0] req_code;
    logic        handler_called;
    logic [15:0] copy_length;
    logic [15:0] buffer_offset;
    logic [1:0]  copy_dir;
    logic [15:0] actual_length;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== rtl/usb_control_endpoint_sequencer.sv =====
// Endpoint-zero control transfer sequencer, device side.
// Depends on ucep_pkg for codes, stage type and word layouts.

// One token word in gives one result word out. Tokens are SETUP, IN, OUT
// and the two whole-request parameter calls; the block keeps the eight
// setup bytes, the transfer length and the running data offset, and steps
// idle -> data -> ack (or param) as the host drives the transfer. The class
// handler's outcome comes in with the token and is used only where the
// result says handler_called. A token is held in the input register, the
// stage logic works on it there and the result lands in the output
// register, and a new token is taken every cycle while the result side
// keeps draining. If the result register is full and not taken, the
// input register holds one further token and then tready drops.
module usb_control_endpoint_sequencer #(
  // largest request length accepted, in bytes
  parameter int BUF_BYTES = ucep_pkg::BUF_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // setup_word[63:0], packet_size[76:64], handler_status[78:77],
  // handler_length[94:79], zero[95]
  input  logic [95:0]  s_tdata,
  // command[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], actual_length[17:2], copy_dir[19:18], buffer_offset[35:20],
  // copy_length[51:36], handler_called[52], req_code[68:53],
  // req_value[84:69], req_index[100:85], zero[103:101]
  output logic [103:0] m_tdata
);
  import ucep_pkg::*;

  localparam logic [16:0] BUF_LIMIT = 17'(BUF_BYTES);

  // input register
  logic        in_valid;
  token_t      in_tok;
  logic [2:0]  in_cmd;

  // sequencer state
  stage_t      stage, stage_next;
  logic [63:0] setup_bytes, setup_bytes_next;
  logic [15:0] transfer_length, transfer_length_next;
  logic [15:0] transfer_offset, transfer_offset_next;

  // result register
  logic        out_valid;
  result_t     res, res_next;

  logic        advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, res};

  // stage logic
  logic [1:0]  hstat;
  logic        dir_in_held;
  logic [15:0] req_len;
  logic        len_ok;
  logic [15:0] psize;
  logic [15:0] hclamp;
  logic [15:0] rem;
  logic [15:0] dlen;
  logic [15:0] off_sum;
  logic [15:0] pclen_out;
  logic [15:0] pclen_in;

  always_comb begin
    hstat       = (in_tok.handler_status == RS_BAD) ? RS_STALL : in_tok.handler_status;
    dir_in_held = setup_bytes[DIR_IN_BIT];
    req_len     = in_tok.setup_word[63:48];
    len_ok      = {1'b0, req_len} <= BUF_LIMIT;
    psize       = {3'b000, in_tok.packet_size};
    hclamp      = (in_tok.handler_length < req_len) ? in_tok.handler_length : req_len;
    rem         = (transfer_offset < transfer_length) ?
                  (transfer_length - transfer_offset) : 16'd0;
    dlen        = (rem < psize) ? rem : psize;
    off_sum     = transfer_offset + dlen;
    pclen_out   = (req_len < psize) ? req_len : psize;
    pclen_in    = (hclamp < psize) ? hclamp : psize;

    stage_next           = stage;
    setup_bytes_next     = setup_bytes;
    transfer_length_next = transfer_length;
    transfer_offset_next = transfer_offset;

    res_next                = '0;
    res_next.status         = RS_OK;
    res_next.copy_dir       = CD_NONE;

    case (in_cmd)
      CMD_SETUP: begin
        if (in_tok.packet_size != SETUP_LEN) begin
          res_next.status = RS_STALL;
        end else begin
          setup_bytes_next = in_tok.setup_word;
          if (!len_ok) begin
            res_next.status = RS_STALL;
          end else begin
            transfer_length_next = req_len;
            transfer_offset_next = '0;
            if (in_tok.setup_word[DIR_IN_BIT]) begin
              res_next.handler_called = 1'b1;
              res_next.status         = hstat;
              if (hstat == RS_ASYNC) begin
                stage_next             = STG_SETUP;
                res_next.actual_length = in_tok.handler_length;
              end else if (hstat != RS_OK) begin
                res_next.actual_length = in_tok.handler_length;
              end else begin
                transfer_length_next   = hclamp;
                stage_next             = STG_DATA;
                res_next.actual_length = 16'(SETUP_LEN);
              end
            end else begin
              stage_next             = (req_len == 16'd0) ? STG_ACK : STG_DATA;
              res_next.actual_length = 16'(SETUP_LEN);
            end
          end
        end
      end
      CMD_IN, CMD_OUT: begin
        if (stage == STG_ACK) begin
          if (in_cmd == CMD_IN) begin
            // status stage of a host-to-device request
            if (!dir_in_held) begin
              res_next.handler_called = 1'b1;
              res_next.status         = hstat;
              if (hstat == RS_ASYNC) begin
                res_next.actual_length = in_tok.handler_length;
              end else begin
                stage_next = STG_IDLE;
              end
            end
          end else if (dir_in_held) begin
            stage_next = STG_IDLE;
          end
        end else if (stage == STG_DATA) begin
          if (dir_in_held == (in_cmd == CMD_IN)) begin
            res_next.copy_dir      = (in_cmd == CMD_IN) ? CD_TO_PKT : CD_TO_BUF;
            res_next.buffer_offset = transfer_offset;
            res_next.copy_length   = dlen;
            res_next.actual_length = dlen;
            transfer_offset_next   = off_sum;
            if (off_sum >= transfer_length) begin
              stage_next = STG_ACK;
            end
          end else begin
            stage_next      = STG_IDLE;
            res_next.status = RS_STALL;
          end
        end else begin
          res_next.status = RS_STALL;
        end
      end
      CMD_PARAM_OUT, CMD_PARAM_IN: begin
        setup_bytes_next     = in_tok.setup_word;
        stage_next           = STG_PARAM;
        transfer_offset_next = '0;
        if (!len_ok) begin
          res_next.status = RS_STALL;
        end else begin
          transfer_length_next = req_len;
          if (in_cmd == CMD_PARAM_OUT) begin
            res_next.copy_dir    = CD_TO_BUF;
            res_next.copy_length = pclen_out;
          end
          res_next.handler_called = 1'b1;
          res_next.status         = hstat;
          res_next.actual_length  = in_tok.handler_length;
          if (hstat != RS_ASYNC) begin
            transfer_length_next = hclamp;
            if (in_cmd == CMD_PARAM_IN) begin
              res_next.copy_dir      = CD_TO_PKT;
              res_next.copy_length   = pclen_in;
              res_next.actual_length = pclen_in;
            end
          end
        end
      end
      default: begin
        res_next.status = RS_STALL;
      end
    endcase

    // request fields come from the setup bytes held after this token
    res_next.req_code  = {setup_bytes_next[7:0], setup_bytes_next[15:8]};
    res_next.req_value = setup_bytes_next[31:16];
    res_next.req_index = setup_bytes_next[47:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      stage           <= STG_IDLE;
      setup_bytes     <= '0;
      transfer_length <= '0;
      transfer_offset <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        stage           <= stage_next;
        setup_bytes     <= setup_bytes_next;
        transfer_length <= transfer_length_next;
        transfer_offset <= transfer_offset_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_tok <= token_t'(s_tdata[94:0]);
      in_cmd <= s_tuser;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // the length check keeps the transfer inside the buffer
  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, transfer_length} <= BUF_LIMIT)
    else $error("transfer length beyond buffer size");

  a_off_bounded: assert property (@(posedge clk) disable iff (rst)
    transfer_offset <= transfer_length)
    else $error("data offset past transfer length");

  a_no_copy_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.copy_dir == CD_NONE) |->
      (res.copy_length == 16'd0) && (res.buffer_offset == 16'd0))
    else $error("copy fields set with no copy");

  a_in_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.copy_dir == CD_TO_PKT) |-> res.actual_length == res.copy_length)
    else $error("IN copy length differs from packet length");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without a blocked result");

endmodule
